>>> rtl/core/rqss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqss_pkg
// Shared types, sizes and helpers of the record queue with search and sort.
// ----------------------------------------------------------------------------
package rqss_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_CHARS = 8;
    localparam int IW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int OP_W      = 3;
    localparam int POS_W     = 5;
    localparam int ST_W      = 3;
    localparam int REC_W     = 64;
    localparam int KEY_SHIFT = REC_W - 8 * KEY_CHARS;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ   = 3'd0,
        OP_DEQ   = 3'd1,
        OP_LIST  = 3'd2,
        OP_SRCH  = 3'd3,
        OP_SORT  = 3'd4,
        OP_OVW   = 3'd5,
        OP_CLR   = 3'd6
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_FULL   = 3'd2,
        ST_NOTFND = 3'd3,
        ST_BADPOS = 3'd4
    } t_status;

    // what the output register is loaded with
    typedef enum logic [1:0] {
        OK_ZERO,
        OK_ENQ,
        OK_INPUT,
        OK_READ
    } t_okind;

    typedef struct packed {
        logic    take;
        logic    rd_en;
        logic    rd_best;
        logic    idx_clr;
        logic    idx_inc;
        logic    rank_clr;
        logic    rank_inc;
        logic    best_clr;
        logic    prev_clr;
        logic    scan_step;
        logic    prev_load;
        logic    wr_en;
        logic    head_inc;
        logic    fill_inc;
        logic    fill_dec;
        logic    fill_clr;
        logic    out_load;
        t_okind  out_kind;
        t_status out_status;
        logic    out_last;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic fill_zero;
        logic full;
        logic pos_bad;
        logic idx_last;
        logic rank_last;
        logic key_hit;
        logic can_load;
    } t_sts;

    // ring slot of a 0-based queue offset
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                              input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IW+1)'(DEPTH)) sum = sum - (IW+1)'(DEPTH);
        return sum[IW-1:0];
    endfunction

    // compared part of a name
    function automatic logic [REC_W-1:0] key_of(input logic [REC_W-1:0] nm);
        return nm & ({REC_W{1'b1}} << KEY_SHIFT);
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/record_queue_search_sort.sv
`default_nettype none
// ----------------------------------------------------------------------------
// record_queue_search_sort
// Queue of up to 16 name/payload records with search and sorted readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) moves one operation beat:
//   opcode, position, name key and payload. Output channel
//   (o_out_valid / i_out_ready) moves result beats; o_last marks the final
//   beat of an operation. One operation is worked on at a time; o_in_ready
//   rises again once the last result beat is in the output register.
//   Search examines the records one at a time from the front. Sorted
//   readout scans all N records once per output rank through the single
//   store read port.
//   Reset empties the queue; stored records are not cleared. When the
//   receiver stalls, the result beat is held and the sequencer waits
//   before loading the next one.
// ----------------------------------------------------------------------------
module record_queue_search_sort
    import rqss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [REC_W-1:0]  i_name_key,
    input  wire logic [REC_W-1:0]  i_payload,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [ST_W-1:0]        o_status,
    output logic [POS_W-1:0]       o_rec_position,
    output logic [REC_W-1:0]       o_rec_name,
    output logic [REC_W-1:0]       o_rec_payload,
    output logic [POS_W-1:0]       o_occupancy,
    output logic                   o_last
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    rqss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // store and output register
    rqss_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_opcode),
        .i_position     (i_position),
        .i_name_key     (i_name_key),
        .i_payload      (i_payload),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_rec_position (o_rec_position),
        .o_rec_name     (o_rec_name),
        .o_rec_payload  (o_rec_payload),
        .o_occupancy    (o_occupancy),
        .o_last         (o_last)
    );

`ifndef SYNTH
    // one operation at a time
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a beat while busy");

    // error results carry no record and end the operation
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_last && (o_rec_position == '0)))
        else $error("error beat with record or not last");

    // occupancy never above capacity
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_occupancy <= POS_W'(DEPTH)))
        else $error("occupancy over capacity");
`endif

endmodule
`default_nettype wire

>>> rtl/core/rqss_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqss_dpath
// Record store, queue pointers, scan registers and the output register.
// ----------------------------------------------------------------------------
module rqss_dpath
    import rqss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [REC_W-1:0]  i_name_key,
    input  wire logic [REC_W-1:0]  i_payload,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [ST_W-1:0]        o_status,
    output logic [POS_W-1:0]       o_rec_position,
    output logic [REC_W-1:0]       o_rec_name,
    output logic [REC_W-1:0]       o_rec_payload,
    output logic [POS_W-1:0]       o_occupancy,
    output logic                   o_last
);

    logic [REC_W-1:0] r_mem_name [DEPTH];
    logic [REC_W-1:0] r_mem_pay  [DEPTH];
    logic [REC_W-1:0] r_rd_name, r_rd_pay;
    t_op              r_op;
    logic [POS_W-1:0] r_pos;
    logic [REC_W-1:0] r_nm, r_pl;
    logic [IW-1:0]    r_head;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    r_idx, r_rank;
    logic [IW-1:0]    r_cmp_idx, r_best, r_prev;
    logic [REC_W-1:0] r_best_key, r_prev_key;
    logic             r_have_best, r_have_prev;
    logic             r_out_valid;
    logic [ST_W-1:0]  r_status;
    logic [POS_W-1:0] r_rpos, r_occ;
    logic [REC_W-1:0] r_oname, r_opay;
    logic             r_last;
    logic [IW-1:0]    rd_off, wr_slot;
    logic [REC_W-1:0] rd_key;
    logic             cand_ok, better, can_load;
    logic [POS_W-1:0] pos_m1;

    assign rd_key   = key_of(r_rd_name);
    assign can_load = !r_out_valid || i_out_ready;
    assign rd_off   = i_cmd.rd_best ? r_best : r_idx[IW-1:0];
    assign pos_m1   = r_pos - POS_W'(1);
    assign wr_slot  = (r_op == OP_OVW) ? slot_of(r_head, pos_m1[IW-1:0])
                                       : slot_of(r_head, r_fill[IW-1:0]);

    // next fill count
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.fill_clr)      n_fill = '0;
        else if (i_cmd.fill_inc) n_fill = r_fill + CW'(1);
        else if (i_cmd.fill_dec) n_fill = r_fill - CW'(1);
    end

    // record after the previous rank and before the current best
    always_comb begin
        cand_ok = !r_have_prev || (rd_key > r_prev_key) ||
                  ((rd_key == r_prev_key) && (r_cmp_idx > r_prev));
        better  = cand_ok && (!r_have_best || (rd_key < r_best_key));
    end

    // status to the controller
    always_comb begin
        o_sts.op        = r_op;
        o_sts.fill_zero = (r_fill == '0);
        o_sts.full      = (r_fill >= CW'(DEPTH));
        o_sts.pos_bad   = (r_pos == '0) || (r_pos > POS_W'(r_fill));
        o_sts.idx_last  = ((r_idx + CW'(1)) == r_fill);
        o_sts.rank_last = ((r_rank + CW'(1)) == r_fill);
        o_sts.key_hit   = (rd_key == key_of(r_nm));
        o_sts.can_load  = can_load;
    end

    // record store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem_name[wr_slot] <= r_nm;
            r_mem_pay[wr_slot]  <= r_pl;
        end
        if (i_cmd.rd_en) begin
            r_rd_name <= r_mem_name[slot_of(r_head, rd_off)];
            r_rd_pay  <= r_mem_pay[slot_of(r_head, rd_off)];
            r_cmp_idx <= rd_off;
        end
    end

    // captured item and scan payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op  <= t_op'(i_opcode);
            r_pos <= i_position;
            r_nm  <= i_name_key;
            r_pl  <= i_payload;
        end
        if (i_cmd.scan_step && better) begin
            r_best     <= r_cmp_idx;
            r_best_key <= rd_key;
        end
        if (i_cmd.prev_load) begin
            r_prev     <= r_best;
            r_prev_key <= r_best_key;
        end
    end

    // queue pointers and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_rank      <= '0;
            r_have_best <= 1'b0;
            r_have_prev <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.fill_clr)      r_head <= '0;
            else if (i_cmd.head_inc) r_head <= slot_of(r_head, IW'(1));
            if (i_cmd.idx_clr)       r_idx <= '0;
            else if (i_cmd.idx_inc)  r_idx <= r_idx + CW'(1);
            if (i_cmd.rank_clr)      r_rank <= '0;
            else if (i_cmd.rank_inc) r_rank <= r_rank + CW'(1);
            if (i_cmd.best_clr)                  r_have_best <= 1'b0;
            else if (i_cmd.scan_step && better)  r_have_best <= 1'b1;
            if (i_cmd.prev_clr)       r_have_prev <= 1'b0;
            else if (i_cmd.prev_load) r_have_prev <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            r_last   <= i_cmd.out_last;
            r_occ    <= POS_W'(n_fill);
            case (i_cmd.out_kind)
                OK_ENQ: begin
                    r_rpos  <= POS_W'(r_fill + CW'(1));
                    r_oname <= r_nm;
                    r_opay  <= r_pl;
                end
                OK_INPUT: begin
                    r_rpos  <= r_pos;
                    r_oname <= r_nm;
                    r_opay  <= r_pl;
                end
                OK_READ: begin
                    r_rpos  <= POS_W'(CW'(r_cmp_idx) + CW'(1));
                    r_oname <= r_rd_name;
                    r_opay  <= r_rd_pay;
                end
                default: begin
                    r_rpos  <= '0;
                    r_oname <= '0;
                    r_opay  <= '0;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_rec_position = r_rpos;
    assign o_rec_name     = r_oname;
    assign o_rec_payload  = r_opay;
    assign o_occupancy    = r_occ;
    assign o_last         = r_last;

endmodule
`default_nettype wire

>>> rtl/core/rqss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqss_ctrl
// Operation sequencer: decodes each item and steps the datapath through it.
// ----------------------------------------------------------------------------
module rqss_ctrl
    import rqss_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ZERO, S_WRITE,
        S_L_ISSUE, S_L_EMIT,
        S_S_ISSUE, S_S_CMP, S_S_HIT,
        S_T_ISSUE, S_T_CMP, S_T_RD, S_T_EMIT
    } t_state;

    t_state  r_state, n_state;
    t_status r_st, n_st;

    // commands and next state
    always_comb begin
        o_cmd      = '0;
        o_cmd.out_kind   = OK_ZERO;
        o_cmd.out_status = ST_OK;
        n_state    = r_state;
        n_st       = r_st;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.idx_clr  = 1'b1;
                o_cmd.rank_clr = 1'b1;
                o_cmd.best_clr = 1'b1;
                o_cmd.prev_clr = 1'b1;
                n_st           = ST_OK;
                n_state        = S_ZERO;
                case (i_sts.op)
                    OP_ENQ: begin
                        n_st = ST_FULL;
                        if (!i_sts.full) n_state = S_WRITE;
                    end
                    OP_OVW: begin
                        n_st = ST_BADPOS;
                        if (!i_sts.pos_bad) n_state = S_WRITE;
                    end
                    OP_DEQ, OP_LIST: begin
                        n_st = ST_EMPTY;
                        if (!i_sts.fill_zero) n_state = S_L_ISSUE;
                    end
                    OP_SRCH: begin
                        n_st = ST_NOTFND;
                        if (!i_sts.fill_zero) n_state = S_S_ISSUE;
                    end
                    OP_SORT: begin
                        n_st = ST_EMPTY;
                        if (!i_sts.fill_zero) n_state = S_T_ISSUE;
                    end
                    OP_CLR: begin
                        o_cmd.fill_clr = 1'b1;
                    end
                    default: begin
                        n_st = ST_OK;
                    end
                endcase
            end
            S_ZERO: begin
                if (i_sts.can_load) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_st;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_WRITE: begin
                if (i_sts.can_load) begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    if (i_sts.op == OP_ENQ) begin
                        o_cmd.fill_inc = 1'b1;
                        o_cmd.out_kind = OK_ENQ;
                    end else begin
                        o_cmd.out_kind = OK_INPUT;
                    end
                    n_state = S_IDLE;
                end
            end
            // queue-order readout, dequeue is its first beat only
            S_L_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_L_EMIT;
            end
            S_L_EMIT: begin
                if (i_sts.can_load) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OK_READ;
                    if (i_sts.op == OP_DEQ) begin
                        o_cmd.head_inc = 1'b1;
                        o_cmd.fill_dec = 1'b1;
                        o_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end else if (i_sts.idx_last) begin
                        o_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_L_ISSUE;
                    end
                end
            end
            // linear search from the front
            S_S_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_S_CMP;
            end
            S_S_CMP: begin
                if (i_sts.key_hit) begin
                    n_state = S_S_HIT;
                end else if (i_sts.idx_last) begin
                    n_state = S_ZERO;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_S_ISSUE;
                end
            end
            S_S_HIT: begin
                if (i_sts.can_load) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OK_READ;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            // sorted readout: one full scan per rank for the next smallest
            S_T_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_T_CMP;
            end
            S_T_CMP: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_T_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_T_ISSUE;
                end
            end
            S_T_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_best = 1'b1;
                n_state       = S_T_EMIT;
            end
            S_T_EMIT: begin
                if (i_sts.can_load) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_kind  = OK_READ;
                    o_cmd.prev_load = 1'b1;
                    if (i_sts.rank_last) begin
                        o_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.rank_inc = 1'b1;
                        o_cmd.idx_clr  = 1'b1;
                        o_cmd.best_clr = 1'b1;
                        n_state        = S_T_ISSUE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

endmodule
`default_nettype wire
